@@ sv/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// sha_pkg
// types and constants shared by the sha-256 stream hasher
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned ROUNDS = 64;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [6:0] LENGTH_POS = 7'd56;

	// block handed from the front to the back
	typedef struct packed {
		logic [511:0] block;
		logic         final_blk;
	} blk_item_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k [0:63];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		round_k = k[r];
	endfunction

	function automatic logic [255:0] init_hash();
		init_hash = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	endfunction

endpackage

@@ sv/sha_front.sv @@
// ----------------------------------------------------------------------------
// sha_front
// gathers bytes into blocks, adds padding and length, issues blocks
// ----------------------------------------------------------------------------
module sha_front
	import sha_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       byte_present,
	input  logic       end_of_message,
	output logic       blk_valid,
	input  logic       blk_ready,
	output blk_item_t  blk
);

	typedef enum logic [2:0] {
		ST_COLLECT = 3'b001,
		ST_PAD1    = 3'b010,
		ST_PAD2    = 3'b100
	} front_state_t;

	front_state_t state_q;
	logic [511:0] buf_q;
	logic [5:0]   fill_q;
	logic [63:0]  len_q;
	logic         out_v_q;
	blk_item_t    out_q;

	logic         slot_free;
	logic         acc;
	logic [511:0] buf_b;
	logic [6:0]   fill_b;
	logic         full_b;
	logic [63:0]  len_b;
	logic [511:0] padded;
	logic [63:0]  bits_b;

	assign slot_free = !out_v_q || blk_ready;
	assign in_ready  = (state_q == ST_COLLECT) && slot_free;
	assign acc       = in_valid && in_ready;
	assign blk_valid = out_v_q;
	assign blk       = out_q;

	// buffer with this item's byte placed, byte 0 in the top bits
	always_comb begin
		buf_b  = buf_q;
		fill_b = {1'b0, fill_q};
		len_b  = len_q;
		if (byte_present) begin
			buf_b[511 - 8 * fill_q -: 8] = data_byte;
			fill_b = fill_b + 7'd1;
			len_b  = len_q + 64'd1;
		end
		full_b = fill_b[6];
		bits_b = {len_b[60:0], 3'b000};
	end

	// padding of the buffered bytes: mark, zeros, length if it fits
	always_comb begin
		padded = buf_b;
		for (int i = 0; i < 64; i++) begin
			if (i == int'(fill_b[5:0])) padded[511 - 8 * i -: 8] = PAD_MARK;
			else if (i > int'(fill_b[5:0])) padded[511 - 8 * i -: 8] = 8'h00;
		end
		if ({1'b0, fill_b[5:0]} < LENGTH_POS) padded[63:0] = bits_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			fill_q  <= '0;
			len_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (blk_ready) out_v_q <= 1'b0;
			case (state_q)
				ST_COLLECT: begin
					if (acc) begin
						buf_q  <= buf_b;
						fill_q <= fill_b[5:0];
						len_q  <= len_b;
						if (full_b) begin
							out_v_q         <= 1'b1;
							out_q.block     <= buf_b;
							out_q.final_blk <= 1'b0;
							if (end_of_message) state_q <= ST_PAD2;
						end else if (end_of_message) begin
							out_v_q         <= 1'b1;
							out_q.block     <= padded;
							out_q.final_blk <= ({1'b0, fill_b[5:0]} < LENGTH_POS);
							if ({1'b0, fill_b[5:0]} >= LENGTH_POS) state_q <= ST_PAD1;
						end
					end
				end
				ST_PAD1: begin
					// length only block
					if (slot_free) begin
						out_v_q         <= 1'b1;
						out_q.block     <= {448'd0, len_q[60:0], 3'b000};
						out_q.final_blk <= 1'b1;
						fill_q          <= '0;
						len_q           <= '0;
						state_q         <= ST_COLLECT;
					end
				end
				ST_PAD2: begin
					// full block ended the message: mark plus length
					if (slot_free) begin
						out_v_q         <= 1'b1;
						out_q.block     <= {PAD_MARK, 440'd0, len_q[60:0], 3'b000};
						out_q.final_blk <= 1'b1;
						fill_q          <= '0;
						len_q           <= '0;
						state_q         <= ST_COLLECT;
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
			if (state_q == ST_COLLECT && acc && end_of_message && !full_b &&
				({1'b0, fill_b[5:0]} < LENGTH_POS)) begin
				fill_q <= '0;
				len_q  <= '0;
			end
		end
	end

endmodule

@@ sv/sha_queue.sv @@
// ----------------------------------------------------------------------------
// sha_queue
// two entry block queue between front and back
// ----------------------------------------------------------------------------
module sha_queue
	import sha_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_valid,
	output logic      wr_ready,
	input  blk_item_t wr_item,
	output logic      rd_valid,
	input  logic      rd_ready,
	output blk_item_t rd_item
);

	blk_item_t  mem_q [0:1];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       wr;
	logic       rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_item  = mem_q[rp_q];
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule

@@ sv/sha_back.sv @@
// ----------------------------------------------------------------------------
// sha_back
// one round per cycle compression and digest word output
// ----------------------------------------------------------------------------
module sha_back
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        blk_valid,
	output logic        blk_ready,
	input  blk_item_t   blk,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ROUND = 4'b0010,
		ST_ADD   = 4'b0100,
		ST_EMIT  = 4'b1000
	} back_state_t;

	back_state_t  state_q;
	logic [31:0]  w_q [0:15];
	logic [31:0]  v_q [0:7];
	logic [255:0] chain_q;
	logic [5:0]   rnd_q;
	logic         fin_q;
	logic [2:0]   idx_q;

	logic [31:0] w_new, wr, t1, t2, s0, s1;

	assign blk_ready   = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_EMIT);
	assign digest_word = chain_q[255 - 32 * idx_q -: 32];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd7);

	always_comb begin
		s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		wr    = w_q[0];
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25)) +
			((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q) + wr;
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22)) +
			((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// schedule and working registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && blk_valid) begin
			for (int i = 0; i < 16; i++) w_q[i] <= blk.block[511 - 32 * i -: 32];
			for (int i = 0; i < 8; i++) v_q[i] <= chain_q[255 - 32 * i -: 32];
		end else if (state_q == ST_ROUND) begin
			// window shifts so w_q[0] is always the current round word
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chain_q <= init_hash();
			rnd_q   <= '0;
			fin_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (blk_valid) begin
						fin_q   <= blk.final_blk;
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++)
						chain_q[255 - 32 * i -: 32] <= chain_q[255 - 32 * i -: 32] + v_q[i];
					idx_q   <= '0;
					state_q <= fin_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							chain_q <= init_hash();
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ sv/sha256_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// streaming sha-256: bytes in, eight digest words out per message
// ----------------------------------------------------------------------------
// input channel s_axis: one item per byte; tuser[0] marks a byte present,
// tlast ends the message (an item with no byte and tlast ends it too).
// output channel m_axis: eight digest words, word 0 (most significant)
// first, tuser carries the word index, tlast is set on word 7.
// the front takes one byte a cycle while tready is high and hands each
// 64-byte block through a two-entry queue to the compressor, which runs
// one round a cycle while later blocks are gathered behind it. end of
// message adds one or two padded blocks; the first digest word is valid
// once the last block's rounds are added into the chaining value. while
// the receiver stalls the word is held; the front keeps filling until the
// queue is full and its output block waits, then drops tready. reset
// returns the chaining value to the initial hash and clears counts.
// ----------------------------------------------------------------------------
module sha256_stream_hasher
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tuser,   // byte_present
	input  logic        s_axis_tlast,   // end_of_message
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // digest_word
	output logic [2:0]  m_axis_tuser,   // word_index
	output logic        m_axis_tlast    // last_word
);

	logic      f_valid, f_ready, b_valid, b_ready;
	blk_item_t f_item, b_item;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.data_byte(s_axis_tdata), .byte_present(s_axis_tuser),
		.end_of_message(s_axis_tlast),
		.blk_valid(f_valid), .blk_ready(f_ready), .blk(f_item)
	);

	sha_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
	);

	sha_back u_back (
		.clk(clk), .arst_n(arst_n),
		.blk_valid(b_valid), .blk_ready(b_ready), .blk(b_item),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.digest_word(m_axis_tdata), .word_index(m_axis_tuser),
		.last_word(m_axis_tlast)
	);

endmodule

@@ tb/sha256_stream_hasher_tb.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher_tb
// drives byte items with end markers into the hasher, predicts each digest
// with a behavioural sha-256 and checks every digest word in order
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_word_t;

	digest_word_t digest_q[$];
	int           fail_count = 0;
	int           burst_left = 0;
	int           items_sent = 0;
	int           stall_mode = 0;

	// predictor state
	logic [31:0] hash_state [8];
	logic [7:0]  msg_block [64];
	int          fill;
	logic [63:0] byte_total;

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
	localparam logic [31:0] IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
		32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	sha256_stream_hasher u_top (.*);

	always #5 clk = ~clk;

	function automatic logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic hash_restart();
		foreach (hash_state[i]) hash_state[i] = IV[i];
		fill = 0;
		byte_total = '0;
	endtask

	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int k = 0; k < 16; k++)
			w[k] = {msg_block[4*k], msg_block[4*k+1], msg_block[4*k+2], msg_block[4*k+3]};
		for (int r = 16; r < 64; r++)
			w[r] = w[r-16] + (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3))
				+ w[r-7] + (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10));
		v = hash_state;
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + w[r];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int k = 0; k < 8; k++) hash_state[k] += v[k];
	endtask

	// absorb one item and queue the digest words when the message ends
	task automatic absorb_item(logic [7:0] b, logic present, logic eom);
		logic [63:0] bits;
		if (present) begin
			msg_block[fill] = b;
			fill++;
			byte_total++;
			if (fill == 64) begin
				compress_block();
				fill = 0;
			end
		end
		if (!eom) return;
		bits = byte_total << 3;
		msg_block[fill] = 8'h80;
		fill++;
		if (fill > 56) begin
			for (int k = fill; k < 64; k++) msg_block[k] = '0;
			compress_block();
			fill = 0;
		end
		for (int k = fill; k < 56; k++) msg_block[k] = '0;
		for (int k = 0; k < 8; k++) msg_block[63-k] = bits[8*k +: 8];
		compress_block();
		for (int k = 0; k < 8; k++) digest_q.push_back('{hash_state[k], 3'(k), k == 7});
		hash_restart();
	endtask

	task automatic send_item(logic [7:0] b, logic present, logic eom);
		int gap;
		// random gaps between bursts
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= present;
		s_axis_tlast  <= eom;
		do @(posedge clk); while (!s_axis_tready);
		absorb_item(b, present, eom);
		items_sent++;
	endtask

	task automatic send_message(int len);
		for (int i = 0; i < len; i++) send_item(8'($urandom), 1'b1, i == len - 1);
		if (len == 0) send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic drain_wait();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (digest_q.size() != 0);
	endtask

	task automatic test_directed();
		send_item(8'h00, 1'b0, 1'b1);               // empty message
		send_item(8'h61, 1'b1, 1'b0);               // "abc"
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);               // idle item, ignored
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h55, 1'b0, 1'b1);               // end carries no byte
		send_item(8'haa, 1'b0, 1'b0);
		send_item(8'hff, 1'b1, 1'b1);
		// empty message again, the byte is ignored
		send_item(8'hff, 1'b0, 1'b1);
	endtask

	// lengths around the padding and block boundaries
	task automatic test_boundaries();
		int lens [3] = '{55, 56, 64};
		foreach (lens[i]) send_message(lens[i]);
		drain_wait();
	endtask

	task automatic test_random();
		int len;
		while (items_sent < 218) begin
			case ($urandom_range(0, 5))
				0: len = $urandom_range(0, 3);
				default: len = $urandom_range(1, 12);
			endcase
			// occasional ignored noise items
			if ($urandom_range(0, 3) == 0) send_item(8'($urandom), 1'b0, 1'b0);
			send_message(len);
		end
	endtask

	// receiver stall pattern: phases of always ready, random, and long stalls
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= $urandom_range(0, 1);
			default: m_axis_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		digest_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (digest_q.size() == 0) begin
				report("unexpected word", m_axis_tdata, '0);
			end else begin
				want = digest_q.pop_front();
				if (m_axis_tdata !== want.word) report("digest_word", m_axis_tdata, want.word);
				if (m_axis_tuser !== want.idx)
					report("word_index", 32'(m_axis_tuser), 32'(want.idx));
				if (m_axis_tlast !== want.last)
					report("last_word", 32'(m_axis_tlast), 32'(want.last));
			end
		end
	end

	initial begin
		hash_restart();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		drain_wait();
		test_boundaries();
		test_random();
		drain_wait();
		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("sha256_stream_hasher test passed");
		end else begin
			$display("sha256_stream_hasher test failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("sha256_stream_hasher test failed");
		$finish;
	end

endmodule
